// ----- hw/rtl/stereo_point_adjacent_distance_assert.svh -----
// Assertion macros used by the checker file.
`ifndef STEREO_POINT_ADJACENT_DISTANCE_ASSERT_SVH
`define STEREO_POINT_ADJACENT_DISTANCE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spad assertion failed");

// Next-cycle implication, disabled during reset.
`define SPAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spad assertion failed");

`endif

// ----- hw/rtl/spad_pkg.sv -----
package spad_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

  // Shift-subtract unit sizing.
  localparam int DIV_W       = 50;
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int DEN_W       = 16;
  localparam int STEP_W      = 6;
  localparam logic [STEP_W-1:0] DIV_LAST  = 6'd49;
  localparam logic [STEP_W-1:0] SQRT_LAST = 6'd31;

  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_FB,
    S_DIV_Z,
    S_MUL_X,
    S_DIV_X,
    S_MUL_Y,
    S_DIV_Y,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_Z,
    S_SQ_ACC,
    S_SQRT,
    S_FIN
  } state_t;

  // Request from the sequencer to the shift-subtract unit.
  typedef struct packed {
    logic             start;
    mode_t            mode;
    logic [RAD_W-1:0] num;
    logic [DEN_W-1:0] den;
  } unit_req_t;

  // Response from the shift-subtract unit.
  typedef struct packed {
    logic             done;
    logic [RAD_W-1:0] res;
  } unit_rsp_t;

endpackage

// ----- hw/rtl/spad_if.sv -----
// Input point channel.
interface spad_point_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_x;
  logic [15:0] left_y;
  logic [15:0] right_x;
  logic        start_of_set;

  modport source (output valid, left_x, left_y, right_x, start_of_set, input ready);
  modport sink (input valid, left_x, left_y, right_x, start_of_set, output ready);
endinterface

// Result channel.
interface spad_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               point_ok;
  logic [31:0]        distance;
  logic               distance_ok;
  logic [47:0]        run_total;
  logic [15:0]        valid_count;

  modport source (output valid, pos_x, pos_y, pos_z, point_ok, distance, distance_ok,
                  run_total, valid_count, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, point_ok, distance, distance_ok,
                run_total, valid_count, output ready);
endinterface

// ----- hw/rtl/spad_shsub.sv -----
// Radix-2 shift-subtract unit: unsigned division or integer square root.
module spad_shsub (
  input  logic                  clk,
  input  logic                  rst,
  input  spad_pkg::unit_req_t   req,
  output spad_pkg::unit_rsp_t   rsp
);

  logic                          busy;
  logic                          done;
  spad_pkg::mode_t               mode;
  logic [spad_pkg::STEP_W-1:0]   cnt;
  logic [34:0]                   rem;
  logic [spad_pkg::RAD_W-1:0]    acc;
  logic [spad_pkg::ROOT_W-1:0]   root;
  logic [spad_pkg::DEN_W-1:0]    den;

  logic [16:0] drem;
  logic        dfit;
  logic [34:0] srem;
  logic [34:0] strial;
  logic        sfit;
  logic [spad_pkg::STEP_W-1:0] last;

  // One step of each algorithm.
  always_comb begin
    drem   = {rem[15:0], acc[spad_pkg::RAD_W-1]};
    dfit   = drem >= {1'b0, den};
    srem   = {rem[32:0], acc[spad_pkg::RAD_W-1 -: 2]};
    strial = {1'b0, root, 2'b01};
    sfit   = srem >= strial;
    last   = (mode == spad_pkg::MODE_DIV) ? spad_pkg::DIV_LAST : spad_pkg::SQRT_LAST;
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      den  <= req.den;
      rem  <= '0;
      root <= '0;
      if (req.mode == spad_pkg::MODE_DIV) begin
        acc <= {req.num[spad_pkg::DIV_W-1:0], {(spad_pkg::RAD_W-spad_pkg::DIV_W){1'b0}}};
      end else begin
        acc <= req.num;
      end
    end else if (busy) begin
      if (mode == spad_pkg::MODE_DIV) begin
        rem <= dfit ? {18'd0, drem - {1'b0, den}} : {18'd0, drem};
        acc <= {acc[spad_pkg::RAD_W-2:0], dfit};
      end else begin
        rem  <= sfit ? (srem - strial) : srem;
        root <= {root[spad_pkg::ROOT_W-2:0], sfit};
        acc  <= {acc[spad_pkg::RAD_W-3:0], 2'b00};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = (mode == spad_pkg::MODE_SQRT) ?
                    {{(spad_pkg::RAD_W-spad_pkg::ROOT_W){1'b0}}, root} : acc;

endmodule

// ----- hw/rtl/stereo_point_adjacent_distance.sv -----
// Channel | Direction | Payload
// point   | in        | left_x, left_y, right_x, start_of_set
// result  | out       | pos_x/y/z, point_ok, distance, distance_ok, total, count
//
// A rejected point goes straight to the finish state; a valid point runs the
// divisions, and the squares and square root when a distance is computed. The shared radix-2 shift-subtract
// unit does this work: each of the divisions for z, x and y runs 50 steps,
// and the square root runs 32 steps.
// Reset (rst, synchronous) restores the register defaults and clears the chain.
// The result register lets a new point start while the last result waits.
module stereo_point_adjacent_distance (
  input  logic                            clk,
  input  logic                            rst,
  spad_point_if.sink                      point,
  spad_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [spad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);

  // Saturate a sign and magnitude to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic neg,
                                               input logic [spad_pkg::DIV_W-1:0] mag);
    logic signed [31:0] r;
    if (neg) begin
      if (mag > 50'h0_0000_8000_0000) r = 32'sh8000_0000;
      else                            r = -$signed(mag[31:0]);
    end else begin
      if (mag > 50'h0_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else                            r = $signed(mag[31:0]);
    end
    return r;
  endfunction

  // Configuration registers.
  logic [15:0] focal, base, cx, cy, thr;

  // Item and chain state.
  spad_pkg::state_t   state, state_next;
  logic [15:0]        lx, ly;
  logic               d_neg;
  logic [15:0]        mag;
  logic               ok;
  logic signed [31:0] px, py, pz;
  logic signed [31:0] prev_x, prev_y, prev_z;
  logic               prev_ok;
  logic [47:0]        sum_store;
  logic [15:0]        count_store;
  logic [32:0]        zq;
  logic               p_neg;
  logic [65:0]        acc;
  logic [31:0]        span;
  logic               launched;

  // Shared multiplier.
  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;

  spad_pkg::unit_req_t req;
  spad_pkg::unit_rsp_t rsp;

  // Result register.
  logic               res_valid;
  logic signed [31:0] r_x, r_y, r_z;
  logic               r_pok, r_dok;
  logic [31:0]        r_dist;
  logic [47:0]        r_total;
  logic [15:0]        r_count;

  // Accept-time decode.
  logic [16:0] dw;
  logic [15:0] in_mag;
  logic        in_ok;
  logic [16:0] cdx, cdy;
  logic [32:0] ddx, ddy, ddz;
  logic [32:0] sq_x, sq_y, sq_z;
  logic        dok;
  logic [48:0] sum_add;
  logic        out_free;
  logic        take;

  always_comb begin
    dw      = {1'b0, point.left_x} - {1'b0, point.right_x};
    in_mag  = dw[16] ? 16'(-dw) : dw[15:0];
    in_ok   = in_mag > thr;
    cdx     = {1'b0, lx} - {1'b0, cx};
    cdy     = {1'b0, ly} - {1'b0, cy};
    ddx     = {px[31], px} - {prev_x[31], prev_x};
    ddy     = {py[31], py} - {prev_y[31], prev_y};
    ddz     = {pz[31], pz} - {prev_z[31], prev_z};
    sq_x    = ddx[32] ? -ddx : ddx;
    sq_y    = ddy[32] ? -ddy : ddy;
    sq_z    = ddz[32] ? -ddz : ddz;
    dok     = ok && prev_ok;
    sum_add = {1'b0, sum_store} + {17'd0, span};
    out_free = !res_valid || result.ready;
    take    = point.valid && point.ready;
  end

  assign point.ready = (state == spad_pkg::S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      focal <= 16'd16000;
      base  <= 16'd15360;
      cx    <= 16'd10240;
      cy    <= 16'd5760;
      thr   <= 16'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        spad_pkg::REG_FOCAL:     focal <= cfg_data;
        spad_pkg::REG_BASELINE:  base  <= cfg_data;
        spad_pkg::REG_CENTER_X:  cx    <= cfg_data;
        spad_pkg::REG_CENTER_Y:  cy    <= cfg_data;
        spad_pkg::REG_THRESHOLD: thr   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: next state, multiplier operands and unit requests.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    req.start  = 1'b0;
    req.mode   = spad_pkg::MODE_DIV;
    req.num    = {{(spad_pkg::RAD_W-spad_pkg::DIV_W){1'b0}}, prod[spad_pkg::DIV_W-1:0]};
    req.den    = focal;
    case (state)
      spad_pkg::S_IDLE: begin
        if (take) state_next = in_ok ? spad_pkg::S_MUL_FB : spad_pkg::S_FIN;
      end
      spad_pkg::S_MUL_FB: begin
        mul_a      = {17'd0, focal};
        mul_b      = {17'd0, base};
        state_next = spad_pkg::S_DIV_Z;
      end
      spad_pkg::S_DIV_Z: begin
        req.start = !launched;
        req.den   = mag;
        if (rsp.done) begin
          if (focal == 16'd0) state_next = prev_ok ? spad_pkg::S_SQ_X : spad_pkg::S_FIN;
          else                state_next = spad_pkg::S_MUL_X;
        end
      end
      spad_pkg::S_MUL_X: begin
        mul_a      = {17'd0, cdx[16] ? 16'(-cdx) : cdx[15:0]};
        mul_b      = zq;
        state_next = spad_pkg::S_DIV_X;
      end
      spad_pkg::S_DIV_X: begin
        req.start = !launched;
        if (rsp.done) state_next = spad_pkg::S_MUL_Y;
      end
      spad_pkg::S_MUL_Y: begin
        mul_a      = {17'd0, cdy[16] ? 16'(-cdy) : cdy[15:0]};
        mul_b      = zq;
        state_next = spad_pkg::S_DIV_Y;
      end
      spad_pkg::S_DIV_Y: begin
        req.start = !launched;
        if (rsp.done) state_next = prev_ok ? spad_pkg::S_SQ_X : spad_pkg::S_FIN;
      end
      spad_pkg::S_SQ_X: begin
        mul_a      = sq_x;
        mul_b      = sq_x;
        state_next = spad_pkg::S_SQ_Y;
      end
      spad_pkg::S_SQ_Y: begin
        mul_a      = sq_y;
        mul_b      = sq_y;
        state_next = spad_pkg::S_SQ_Z;
      end
      spad_pkg::S_SQ_Z: begin
        mul_a      = sq_z;
        mul_b      = sq_z;
        state_next = spad_pkg::S_SQ_ACC;
      end
      spad_pkg::S_SQ_ACC: begin
        state_next = spad_pkg::S_SQRT;
      end
      spad_pkg::S_SQRT: begin
        req.mode = spad_pkg::MODE_SQRT;
        req.num  = acc[63:0];
        if (acc[65:64] != 2'b00) begin
          state_next = spad_pkg::S_FIN;
        end else begin
          req.start = !launched;
          if (rsp.done) state_next = spad_pkg::S_FIN;
        end
      end
      spad_pkg::S_FIN: begin
        if (out_free) state_next = spad_pkg::S_IDLE;
      end
      default: state_next = spad_pkg::S_IDLE;
    endcase
  end

  spad_shsub u_shsub (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // State register and chain control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= spad_pkg::S_IDLE;
      launched    <= 1'b0;
      prev_ok     <= 1'b0;
      prev_x      <= '0;
      prev_y      <= '0;
      prev_z      <= '0;
      sum_store   <= '0;
      count_store <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (req.start)     launched <= 1'b1;
      else if (rsp.done) launched <= 1'b0;
      if (take && point.start_of_set) begin
        prev_ok     <= 1'b0;
        prev_x      <= '0;
        prev_y      <= '0;
        prev_z      <= '0;
        sum_store   <= '0;
        count_store <= '0;
      end
      if (state == spad_pkg::S_FIN && out_free) begin
        res_valid <= 1'b1;
        prev_x    <= px;
        prev_y    <= py;
        prev_z    <= pz;
        prev_ok   <= ok;
        if (dok) begin
          sum_store <= sum_add[48] ? {48{1'b1}} : sum_add[47:0];
          if (count_store != 16'hFFFF) count_store <= count_store + 1'b1;
        end
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (take) begin
      lx    <= point.left_x;
      ly    <= point.left_y;
      d_neg <= dw[16];
      mag   <= in_mag;
      ok    <= in_ok;
      px    <= '0;
      py    <= '0;
      pz    <= '0;
      span  <= '0;
    end
    case (state)
      spad_pkg::S_DIV_Z: if (rsp.done) begin
        zq <= rsp.res[32:0];
        pz <= sat32(d_neg, {17'd0, rsp.res[32:0]});
      end
      spad_pkg::S_MUL_X: p_neg <= cdx[16] ^ d_neg;
      spad_pkg::S_DIV_X: if (rsp.done) px <= sat32(p_neg, rsp.res[spad_pkg::DIV_W-1:0]);
      spad_pkg::S_MUL_Y: p_neg <= cdy[16] ^ d_neg;
      spad_pkg::S_DIV_Y: if (rsp.done) py <= sat32(p_neg, rsp.res[spad_pkg::DIV_W-1:0]);
      spad_pkg::S_SQ_Y:  acc <= prod;
      spad_pkg::S_SQ_Z:  acc <= acc + prod;
      spad_pkg::S_SQ_ACC: acc <= acc + prod;
      spad_pkg::S_SQRT: begin
        if (acc[65:64] != 2'b00) span <= 32'hFFFF_FFFF;
        else if (rsp.done)       span <= rsp.res[31:0];
      end
      default: ;
    endcase
    if (state == spad_pkg::S_FIN && out_free) begin
      r_x     <= px;
      r_y     <= py;
      r_z     <= pz;
      r_pok   <= ok;
      r_dok   <= dok;
      r_dist  <= dok ? span : 32'd0;
      r_total <= dok ? (sum_add[48] ? {48{1'b1}} : sum_add[47:0]) : sum_store;
      r_count <= (dok && count_store != 16'hFFFF) ? count_store + 1'b1 : count_store;
    end
  end

  // Result channel.
  assign result.valid       = res_valid;
  assign result.pos_x       = r_x;
  assign result.pos_y       = r_y;
  assign result.pos_z       = r_z;
  assign result.point_ok    = r_pok;
  assign result.distance    = r_dist;
  assign result.distance_ok = r_dok;
  assign result.run_total   = r_total;
  assign result.valid_count = r_count;

endmodule

// ----- hw/rtl/spad_check.sv -----
`include "stereo_point_adjacent_distance_assert.svh"

// Port-level checks on the top level.
module spad_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] pos_y,
  input logic signed [31:0] pos_z,
  input logic               point_ok,
  input logic [31:0]        distance,
  input logic               distance_ok
);

  // A waiting result stays valid and keeps its distance.
  `SPAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance))
  // A transfer in starts work, so the block is busy next cycle.
  `SPAD_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  // A rejected point reports the origin.
  `SPAD_ASSERT_NOW(a_bad_point_zero, out_valid && !point_ok,
                   pos_x == 32'sd0 && pos_y == 32'sd0 && pos_z == 32'sd0)
  // A distance needs a valid current point.
  `SPAD_ASSERT_NOW(a_dist_needs_point, out_valid && distance_ok, point_ok)
  // No distance means a zero distance field.
  `SPAD_ASSERT_NOW(a_dist_zero, out_valid && !distance_ok, distance == 32'd0)

endmodule

bind stereo_point_adjacent_distance spad_check u_spad_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (point.valid),
  .in_ready    (point.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .pos_x       (result.pos_x),
  .pos_y       (result.pos_y),
  .pos_z       (result.pos_z),
  .point_ok    (result.point_ok),
  .distance    (result.distance),
  .distance_ok (result.distance_ok)
);

// ----- tb/spad_tb_if.sv -----
`timescale 1ns / 100ps

// Typed payloads that the test drives and predicts.
package spad_tb_types;

  typedef struct {
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic        start_of_set;
  } stereo_point_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               point_ok;
    logic [31:0]        distance;
    logic               distance_ok;
    logic [47:0]        run_total;
    logic [15:0]        valid_count;
  } track_result_t;

endpackage

// ----- tb/tb_stereo_point_adjacent_distance.sv -----
`timescale 1ns / 100ps

module tb_stereo_point_adjacent_distance;

  localparam longint SUM_CEIL = (64'd1 << 48) - 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_POINTS = 1600;

  // Predicts the track of triangulated points and checks each result in order.
  class track_scoreboard;
    logic [15:0] focal, base, cx, cy, thresh;
    logic signed [31:0] last_x, last_y, last_z;
    logic last_ok;
    logic [47:0] path_sum;
    logic [15:0] path_count;
    spad_tb_types::track_result_t pending[$];
    int mismatches;
    int checked;
    int distances_seen;

    function void restore_defaults();
      focal = 16'd16000;
      base = 16'd15360;
      cx = 16'd10240;
      cy = 16'd5760;
      thresh = 16'd16;
      last_x = 0;
      last_y = 0;
      last_z = 0;
      last_ok = 0;
      path_sum = 0;
      path_count = 0;
    endfunction

    function void write_reg(logic [spad_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        spad_pkg::REG_FOCAL:     focal = val;
        spad_pkg::REG_BASELINE:  base = val;
        spad_pkg::REG_CENTER_X:  cx = val;
        spad_pkg::REG_CENTER_Y:  cy = val;
        spad_pkg::REG_THRESHOLD: thresh = val;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] gap_sq(logic signed [31:0] a, logic signed [31:0] b);
      longint d;
      logic [63:0] m;
      d = longint'(a) - longint'(b);
      m = (d < 0) ? -d : d;
      return m * m;
    endfunction

    // Prints one line for a mismatch and counts it.
    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, checked);
    endtask

    // Works out the result that one accepted point will produce.
    function void note_point(spad_tb_types::stereo_point_t p);
      spad_tb_types::track_result_t e;
      longint disp, mag, zq, xq, yq;
      logic [63:0] a, b, c, s, t, span;
      logic over;
      logic [64:0] wide_sum;
      disp = longint'(p.left_x) - longint'(p.right_x);
      mag = disp < 0 ? -disp : disp;
      e.point_ok = mag > longint'(thresh);
      e.pos_x = 0;
      e.pos_y = 0;
      e.pos_z = 0;
      e.distance = 0;
      e.distance_ok = 0;
      if (p.start_of_set) begin
        last_x = 0;
        last_y = 0;
        last_z = 0;
        last_ok = 0;
        path_sum = 0;
        path_count = 0;
      end
      if (e.point_ok) begin
        zq = (longint'(focal) * longint'(base)) / disp;
        xq = 0;
        yq = 0;
        if (focal != 0) begin
          xq = ((longint'(p.left_x) - longint'(cx)) * zq) / longint'(focal);
          yq = ((longint'(p.left_y) - longint'(cy)) * zq) / longint'(focal);
        end
        e.pos_x = clamp32(xq);
        e.pos_y = clamp32(yq);
        e.pos_z = clamp32(zq);
      end
      if (e.point_ok && last_ok) begin
        a = gap_sq(e.pos_x, last_x);
        b = gap_sq(e.pos_y, last_y);
        c = gap_sq(e.pos_z, last_z);
        s = a + b;
        over = s < a;
        t = s + c;
        if (t < s) over = 1;
        if (over) span = 64'hffffffff;
        else begin
          span = floor_root(t);
          if (span > 64'hffffffff) span = 64'hffffffff;
        end
        e.distance = span[31:0];
        e.distance_ok = 1;
        wide_sum = path_sum + span[31:0];
        path_sum = (wide_sum > SUM_CEIL) ? SUM_CEIL[47:0] : wide_sum[47:0];
        if (path_count != 16'hffff) path_count++;
      end
      last_x = e.pos_x;
      last_y = e.pos_y;
      last_z = e.pos_z;
      last_ok = e.point_ok;
      e.run_total = path_sum;
      e.valid_count = path_count;
      pending = {pending, e};
    endfunction

    // Compares one transfer on the result channel with the oldest expectation.
    task check_result(spad_tb_types::track_result_t got);
      spad_tb_types::track_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.distance_ok) distances_seen++;
      if (got.pos_x !== e.pos_x) report_mismatch("pos_x", got.pos_x, e.pos_x);
      if (got.pos_y !== e.pos_y) report_mismatch("pos_y", got.pos_y, e.pos_y);
      if (got.pos_z !== e.pos_z) report_mismatch("pos_z", got.pos_z, e.pos_z);
      if (got.point_ok !== e.point_ok) report_mismatch("point_ok", got.point_ok, e.point_ok);
      if (got.distance !== e.distance) report_mismatch("distance", got.distance, e.distance);
      if (got.distance_ok !== e.distance_ok)
        report_mismatch("distance_ok", got.distance_ok, e.distance_ok);
      if (got.run_total !== e.run_total)
        report_mismatch("run_total", got.run_total, e.run_total);
      if (got.valid_count !== e.valid_count)
        report_mismatch("valid_count", got.valid_count, e.valid_count);
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [spad_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  spad_point_if point_ch ();
  spad_result_if result_ch ();

  stereo_point_adjacent_distance DUT (
    .clk(clk),
    .rst(rst),
    .point(point_ch.sink),
    .result(result_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  track_scoreboard track;
  int cycle_count = 0;
  bit send_busy_free;
  bit hold_results;
  bit drain_free;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stalls, a long hold-off on request, checks on each transfer.
  always @(posedge clk) begin
    spad_tb_types::track_result_t got;
    if (rst) begin
      result_ch.ready <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.pos_x = result_ch.pos_x;
        got.pos_y = result_ch.pos_y;
        got.pos_z = result_ch.pos_z;
        got.point_ok = result_ch.point_ok;
        got.distance = result_ch.distance;
        got.distance_ok = result_ch.distance_ok;
        got.run_total = result_ch.run_total;
        got.valid_count = result_ch.valid_count;
        track.check_result(got);
      end
      if (hold_results) result_ch.ready <= 0;
      else if (drain_free) result_ch.ready <= 1;
      else result_ch.ready <= ($urandom_range(99) >= 29);
    end
  end

  task automatic write_reg(logic [spad_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    track.write_reg(idx, val);
  endtask

  // Offers one point and holds it until the transfer.
  task automatic send_point(spad_tb_types::stereo_point_t p);
    if (!send_busy_free) begin
      while ($urandom_range(99) < 29) begin
        point_ch.valid <= 0;
        @(posedge clk);
      end
    end
    point_ch.valid <= 1;
    point_ch.left_x <= p.left_x;
    point_ch.left_y <= p.left_y;
    point_ch.right_x <= p.right_x;
    point_ch.start_of_set <= p.start_of_set;
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
    track.note_point(p);
  endtask

  task automatic send_fields(int lx, int ly, int rx, bit sos);
    spad_tb_types::stereo_point_t p;
    p.left_x = 16'(lx);
    p.left_y = 16'(ly);
    p.right_x = 16'(rx);
    p.start_of_set = sos;
    send_point(p);
  endtask

  // Waits until every expected result is in, then lets the block settle.
  task automatic wait_idle();
    int guard;
    @(posedge clk);
    point_ch.valid <= 0;
    guard = 0;
    while (track.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (250) @(posedge clk);
  endtask

  // Random point: mostly plausible track points, some extremes and near-threshold cases.
  task automatic send_random_point();
    spad_tb_types::stereo_point_t p;
    int kind;
    int d;
    kind = int'($urandom_range(99));
    p.left_x = 16'($urandom_range(20479, 0));
    p.left_y = 16'($urandom_range(11519, 0));
    d = int'($urandom_range(1200, 20));
    if (kind < 60) begin
      p.right_x = (p.left_x > d) ? 16'(p.left_x - d) : 16'(p.left_x + d);
    end else if (kind < 75) begin
      d = int'(track.thresh) + int'($urandom_range(2)) - 1;
      if (d < 0) d = 0;
      p.right_x = (p.left_x >= d) ? 16'(p.left_x - d) : 16'(p.left_x + d);
    end else begin
      p.left_x = 16'($urandom);
      p.left_y = 16'($urandom);
      p.right_x = (kind < 85) ? 16'(int'(p.left_x) + int'($urandom_range(3)) - 1)
                              : 16'($urandom);
    end
    p.start_of_set = ($urandom_range(99) < 4);
    send_point(p);
  endtask

  task automatic random_phase(int n);
    repeat (n) send_random_point();
  endtask

  initial begin
    track = new();
    track.restore_defaults();
    rst = 1;
    cfg_we = 0;
    cfg_index = spad_pkg::REG_FOCAL;
    cfg_data = 0;
    point_ch.valid = 0;
    point_ch.left_x = 0;
    point_ch.left_y = 0;
    point_ch.right_x = 0;
    point_ch.start_of_set = 0;
    send_busy_free = 0;
    hold_results = 0;
    drain_free = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed points at reset settings: extremes, both disparity signs, threshold edges.
    send_fields(0, 0, 0, 1);
    send_fields(10240, 5760, 10000, 0);
    send_fields(10240, 5760, 10480, 0);
    send_fields(65535, 65535, 0, 0);
    send_fields(0, 0, 65535, 0);
    send_fields(100, 100, 84, 0);
    send_fields(100, 100, 83, 0);
    send_fields(500, 65535, 483, 0);
    send_fields(500, 0, 483, 0);
    send_fields(21845, 43690, 21820, 1);
    send_fields(43690, 21845, 43720, 0);
    wait_idle();

    // Extreme settings: largest product with a tiny disparity saturates every axis.
    write_reg(spad_pkg::REG_FOCAL, 16'hffff);
    write_reg(spad_pkg::REG_BASELINE, 16'hffff);
    write_reg(spad_pkg::REG_CENTER_X, 16'd0);
    write_reg(spad_pkg::REG_CENTER_Y, 16'hffff);
    write_reg(spad_pkg::REG_THRESHOLD, 16'd0);
    send_fields(65535, 0, 65534, 1);
    send_fields(0, 65535, 1, 0);
    send_fields(65535, 0, 65534, 0);
    send_fields(65535, 65535, 65535, 0);
    send_fields(1, 1, 0, 0);
    send_fields(65535, 0, 65534, 0);
    wait_idle();

    // Zero focal length places every valid point at the origin.
    write_reg(spad_pkg::REG_FOCAL, 16'd0);
    write_reg(spad_pkg::REG_CENTER_X, 16'hffff);
    write_reg(spad_pkg::REG_CENTER_Y, 16'd0);
    send_fields(1000, 1000, 900, 1);
    send_fields(2000, 50, 2100, 0);
    send_fields(3, 3, 3, 0);
    wait_idle();

    // Random phases over several settings, first at defaults.
    write_reg(spad_pkg::REG_FOCAL, 16'd16000);
    write_reg(spad_pkg::REG_BASELINE, 16'd15360);
    write_reg(spad_pkg::REG_CENTER_X, 16'd10240);
    write_reg(spad_pkg::REG_CENTER_Y, 16'd5760);
    write_reg(spad_pkg::REG_THRESHOLD, 16'd16);
    random_phase(RANDOM_POINTS / 4);

    // Long receiver hold-off while the sender keeps offering points.
    fork
      begin
        hold_results = 1;
        repeat (1500) @(posedge clk);
        hold_results = 0;
      end
      random_phase(10);
    join
    wait_idle();

    write_reg(spad_pkg::REG_FOCAL, 16'd1);
    write_reg(spad_pkg::REG_BASELINE, 16'd1);
    write_reg(spad_pkg::REG_THRESHOLD, 16'd65535);
    random_phase(RANDOM_POINTS / 8);
    wait_idle();

    write_reg(spad_pkg::REG_FOCAL, 16'($urandom_range(65535, 1)));
    write_reg(spad_pkg::REG_BASELINE, 16'($urandom_range(65535, 1)));
    write_reg(spad_pkg::REG_CENTER_X, 16'($urandom));
    write_reg(spad_pkg::REG_CENTER_Y, 16'($urandom));
    write_reg(spad_pkg::REG_THRESHOLD, 16'($urandom_range(64)));
    send_busy_free = 1;
    drain_free = 1;
    random_phase(RANDOM_POINTS / 8);
    send_busy_free = 0;
    drain_free = 0;
    random_phase(RANDOM_POINTS / 8);
    wait_idle();

    write_reg(spad_pkg::REG_FOCAL, 16'hffff);
    write_reg(spad_pkg::REG_BASELINE, 16'hffff);
    write_reg(spad_pkg::REG_CENTER_X, 16'd0);
    write_reg(spad_pkg::REG_CENTER_Y, 16'd0);
    write_reg(spad_pkg::REG_THRESHOLD, 16'd0);
    random_phase(RANDOM_POINTS / 8);
    wait_idle();

    write_reg(spad_pkg::REG_FOCAL, 16'd16000);
    write_reg(spad_pkg::REG_BASELINE, 16'd15360);
    write_reg(spad_pkg::REG_CENTER_X, 16'd10240);
    write_reg(spad_pkg::REG_CENTER_Y, 16'd5760);
    write_reg(spad_pkg::REG_THRESHOLD, 16'd16);
    random_phase(RANDOM_POINTS / 4);
    wait_idle();

    $display("covered %0d results, %0d with a distance, across six register settings",
             track.checked, track.distances_seen);
    $display("including saturation, zero focal length and a long result stall");
    if (track.mismatches == 0 && track.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results still expected", track.mismatches,
               track.pending.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/spad_pkg.sv
hw/rtl/spad_if.sv
hw/rtl/spad_shsub.sv
hw/rtl/stereo_point_adjacent_distance.sv
hw/rtl/spad_check.sv
tb/spad_tb_if.sv
tb/tb_stereo_point_adjacent_distance.sv
